[rtl/shell_command_tokenizer_defines.svh]
// Assertion macros shared by the shell command tokenizer RTL.
`ifndef SHELL_COMMAND_TOKENIZER_DEFINES_SVH
`define SHELL_COMMAND_TOKENIZER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sct_pkg.sv]
// Types, codes and character classes for the shell command tokenizer.
package sct_pkg;

   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_WORD      = 3'd1;
   localparam logic [2:0] MODE_WORD_ESC  = 3'd2;
   localparam logic [2:0] MODE_LEAD_ESC  = 3'd3;
   localparam logic [2:0] MODE_QUOTE     = 3'd4;
   localparam logic [2:0] MODE_QUOTE_ESC = 3'd5;
   localparam logic [2:0] MODE_SPACE     = 3'd6;
   localparam logic [2:0] MODE_GREATER   = 3'd7;

   localparam logic [2:0] KIND_LIT    = 3'd0;
   localparam logic [2:0] KIND_SPACE  = 3'd1;
   localparam logic [2:0] KIND_IN     = 3'd2;
   localparam logic [2:0] KIND_OUT    = 3'd3;
   localparam logic [2:0] KIND_APPEND = 3'd4;
   localparam logic [2:0] KIND_PIPE   = 3'd5;
   localparam logic [2:0] KIND_SEMI   = 3'd6;
   localparam logic [2:0] KIND_AND    = 3'd7;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       token_end;
      logic       bad_char;
   } sct_tok_type;

   function automatic sct_tok_type sct_make_tok(input logic [2:0] kind, input logic [7:0] ch,
                                                input logic valid, input logic last,
                                                input logic bad);
      sct_tok_type t;
      t.token_kind = kind;
      t.text_byte  = valid ? ch : 8'h00;
      t.byte_valid = valid;
      t.token_end  = last;
      t.bad_char   = bad;
      return t;
   endfunction

   function automatic logic sct_is_space(input logic [7:0] ch);
      return (ch == CH_LF) || (ch == CH_CR) || (ch == CH_TAB) || (ch == CH_SPACE);
   endfunction

   function automatic logic sct_is_word_char(input logic [7:0] ch);
      logic hit;
      hit = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A)) ||
            ((ch >= 8'h30) && (ch <= 8'h39));
      case (ch)
         8'h3F, 8'h23, 8'h2F, 8'h2D, 8'h2E, 8'h2A, 8'h40, 8'h3A, 8'h25, 8'h21,
         8'h5E, 8'h2C, 8'h2B, 8'h28, 8'h29, 8'h60, 8'h27, 8'h5B, 8'h5D, 8'h7B,
         8'h7D, 8'h3D, 8'h24, 8'h5F, 8'h7E: hit = 1'b1;
         default: ;
      endcase
      return hit;
   endfunction

endpackage

[rtl/sct_if.sv]
// Channel interfaces of the shell command tokenizer: input, result and register write.
interface sct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sct_rsp_if #(parameter int POS_WIDTH = 16);
   logic                 valid;
   logic                 ready;
   logic [2:0]           token_kind;
   logic [7:0]           text_byte;
   logic                 byte_valid;
   logic                 token_end;
   logic                 bad_char;
   logic [POS_WIDTH-1:0] pos_line;
   logic [POS_WIDTH-1:0] pos_column;

   modport source (output valid, output token_kind, output text_byte, output byte_valid,
                   output token_end, output bad_char, output pos_line, output pos_column,
                   input ready);
   modport sink   (input valid, input token_kind, input text_byte, input byte_valid,
                   input token_end, input bad_char, input pos_line, input pos_column,
                   output ready);
endinterface

interface sct_csr_if;
   logic valid;
   logic ready;
   logic skip_whitespace;

   modport source (output valid, output skip_whitespace, input ready);
   modport sink   (input valid, input skip_whitespace, output ready);
endinterface

[rtl/sct_lexer.sv]
// Lexer state machine: classifies one byte and produces up to two results.
module sct_lexer import sct_pkg::*; #(
   parameter int POS_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_input,
   input  logic                 cfg_we,
   input  logic                 cfg_skip,
   output logic [1:0]           res_count,
   output sct_tok_type          res0_tok,
   output logic [POS_WIDTH-1:0] res0_line,
   output logic [POS_WIDTH-1:0] res0_col,
   output sct_tok_type          res1_tok,
   output logic [POS_WIDTH-1:0] res1_line,
   output logic [POS_WIDTH-1:0] res1_col
);

   localparam logic [POS_WIDTH-1:0] POS_MAX  = {POS_WIDTH{1'b1}};
   localparam logic [POS_WIDTH-1:0] POS_ZERO = {POS_WIDTH{1'b0}};
   localparam logic [POS_WIDTH-1:0] POS_ONE  = {{(POS_WIDTH-1){1'b0}}, 1'b1};

   function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   logic [2:0]           mode_ff, mode_in;
   logic [POS_WIDTH-1:0] line_ff, line_in;
   logic [POS_WIDTH-1:0] col_ff, col_in;
   logic                 nl_ff, nl_in;
   logic                 done_ff, done_in;
   logic                 skip_ff, skip_in;

   logic [POS_WIDTH-1:0] line_adv, col_adv, col_next;

   logic                 st_v;
   sct_tok_type          st_tok;
   logic [POS_WIDTH-1:0] st_line, st_col;
   logic [2:0]           st_mode;

   logic                 a_v, b_v;
   sct_tok_type          a_tok, b_tok;
   logic [POS_WIDTH-1:0] a_line, a_col, b_line, b_col;

   always_comb begin
      line_adv = nl_ff ? sat_inc(line_ff) : line_ff;
      col_adv  = sat_inc(nl_ff ? POS_ZERO : col_ff);
      col_next = sat_inc(col_adv);
   end

   // Start of a new token from the current byte.
   always_comb begin
      st_v    = 1'b0;
      st_tok  = '0;
      st_line = POS_ZERO;
      st_col  = POS_ZERO;
      st_mode = MODE_IDLE;
      if (sct_is_word_char(in_byte)) begin
         st_mode = MODE_WORD;
         st_v    = 1'b1;
         st_tok  = sct_make_tok(KIND_LIT, in_byte, 1'b1, 1'b0, 1'b0);
      end else if (sct_is_space(in_byte)) begin
         st_mode = MODE_SPACE;
         st_v    = !skip_ff;
         st_tok  = sct_make_tok(KIND_SPACE, in_byte, 1'b1, 1'b0, 1'b0);
      end else begin
         case (in_byte)
            CH_BSLASH: st_mode = MODE_LEAD_ESC;
            CH_QUOTE:  st_mode = MODE_QUOTE;
            CH_GT:     st_mode = MODE_GREATER;
            CH_LT, CH_PIPE, CH_SEMI, CH_AMP: begin
               st_v    = 1'b1;
               st_line = line_adv;
               st_col  = col_next;
               case (in_byte)
                  CH_LT:   st_tok = sct_make_tok(KIND_IN, in_byte, 1'b1, 1'b1, 1'b0);
                  CH_PIPE: st_tok = sct_make_tok(KIND_PIPE, in_byte, 1'b1, 1'b1, 1'b0);
                  CH_SEMI: st_tok = sct_make_tok(KIND_SEMI, in_byte, 1'b1, 1'b1, 1'b0);
                  default: st_tok = sct_make_tok(KIND_AND, in_byte, 1'b1, 1'b1, 1'b0);
               endcase
            end
            default: begin
               st_v    = 1'b1;
               st_tok  = sct_make_tok(KIND_LIT, in_byte, 1'b1, 1'b0, 1'b1);
               st_line = line_adv;
               st_col  = col_adv;
            end
         endcase
      end
   end

   // The first result closes or extends the pending token; the second comes
   // from a new token or finishes a two-result sequence.
   always_comb begin
      a_v     = 1'b0;
      a_tok   = '0;
      a_line  = POS_ZERO;
      a_col   = POS_ZERO;
      b_v     = 1'b0;
      b_tok   = '0;
      b_line  = POS_ZERO;
      b_col   = POS_ZERO;
      mode_in = mode_ff;
      line_in = line_ff;
      col_in  = col_ff;
      nl_in   = nl_ff;
      done_in = done_ff;
      skip_in = cfg_we ? cfg_skip : skip_ff;
      if (step && !done_ff) begin
         line_in = line_adv;
         col_in  = col_adv;
         nl_in   = !end_of_input && (in_byte == CH_LF);
         if (end_of_input) begin
            done_in = 1'b1;
            mode_in = MODE_IDLE;
            a_line  = line_adv;
            a_col   = col_adv;
            case (mode_ff)
               MODE_WORD, MODE_WORD_ESC, MODE_QUOTE: begin
                  a_v   = 1'b1;
                  a_tok = sct_make_tok(KIND_LIT, 8'h00, 1'b0, 1'b1, 1'b0);
               end
               MODE_QUOTE_ESC: begin
                  a_v    = 1'b1;
                  a_tok  = sct_make_tok(KIND_LIT, CH_BSLASH, 1'b1, 1'b0, 1'b0);
                  a_line = POS_ZERO;
                  a_col  = POS_ZERO;
                  b_v    = 1'b1;
                  b_tok  = sct_make_tok(KIND_LIT, 8'h00, 1'b0, 1'b1, 1'b0);
                  b_line = line_adv;
                  b_col  = col_adv;
               end
               MODE_SPACE: begin
                  a_v   = !skip_ff;
                  a_tok = sct_make_tok(KIND_SPACE, 8'h00, 1'b0, 1'b1, 1'b0);
               end
               MODE_GREATER: begin
                  a_v   = 1'b1;
                  a_tok = sct_make_tok(KIND_OUT, CH_GT, 1'b1, 1'b1, 1'b0);
               end
               default: ;
            endcase
         end else begin
            case (mode_ff)
               MODE_WORD: begin
                  if (sct_is_word_char(in_byte)) begin
                     a_v   = 1'b1;
                     a_tok = sct_make_tok(KIND_LIT, in_byte, 1'b1, 1'b0, 1'b0);
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = MODE_WORD_ESC;
                  end else begin
                     a_v     = 1'b1;
                     a_tok   = sct_make_tok(KIND_LIT, 8'h00, 1'b0, 1'b1, 1'b0);
                     a_line  = line_adv;
                     a_col   = col_adv;
                     b_v     = st_v;
                     b_tok   = st_tok;
                     b_line  = st_line;
                     b_col   = st_col;
                     mode_in = st_mode;
                  end
               end
               MODE_WORD_ESC, MODE_LEAD_ESC: begin
                  a_v     = 1'b1;
                  a_tok   = sct_make_tok(KIND_LIT, in_byte, 1'b1, 1'b0, 1'b0);
                  mode_in = MODE_WORD;
               end
               MODE_QUOTE: begin
                  if (in_byte == CH_QUOTE) begin
                     a_v     = 1'b1;
                     a_tok   = sct_make_tok(KIND_LIT, 8'h00, 1'b0, 1'b1, 1'b0);
                     a_line  = line_adv;
                     a_col   = col_next;
                     mode_in = MODE_IDLE;
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = MODE_QUOTE_ESC;
                  end else begin
                     a_v   = 1'b1;
                     a_tok = sct_make_tok(KIND_LIT, in_byte, 1'b1, 1'b0, 1'b0);
                  end
               end
               MODE_QUOTE_ESC: begin
                  a_v     = (in_byte != CH_QUOTE);
                  a_tok   = sct_make_tok(KIND_LIT, CH_BSLASH, 1'b1, 1'b0, 1'b0);
                  b_v     = 1'b1;
                  b_tok   = sct_make_tok(KIND_LIT, in_byte, 1'b1, 1'b0, 1'b0);
                  mode_in = MODE_QUOTE;
               end
               MODE_SPACE: begin
                  if (sct_is_space(in_byte)) begin
                     a_v   = !skip_ff;
                     a_tok = sct_make_tok(KIND_SPACE, in_byte, 1'b1, 1'b0, 1'b0);
                  end else begin
                     a_v     = !skip_ff;
                     a_tok   = sct_make_tok(KIND_SPACE, 8'h00, 1'b0, 1'b1, 1'b0);
                     a_line  = line_adv;
                     a_col   = col_adv;
                     b_v     = st_v;
                     b_tok   = st_tok;
                     b_line  = st_line;
                     b_col   = st_col;
                     mode_in = st_mode;
                  end
               end
               MODE_GREATER: begin
                  if (in_byte == CH_GT) begin
                     a_v     = 1'b1;
                     a_tok   = sct_make_tok(KIND_APPEND, CH_GT, 1'b1, 1'b0, 1'b0);
                     b_v     = 1'b1;
                     b_tok   = sct_make_tok(KIND_APPEND, CH_GT, 1'b1, 1'b1, 1'b0);
                     b_line  = line_adv;
                     b_col   = col_next;
                     mode_in = MODE_IDLE;
                  end else begin
                     a_v     = 1'b1;
                     a_tok   = sct_make_tok(KIND_OUT, CH_GT, 1'b1, 1'b1, 1'b0);
                     a_line  = line_adv;
                     a_col   = col_adv;
                     b_v     = st_v;
                     b_tok   = st_tok;
                     b_line  = st_line;
                     b_col   = st_col;
                     mode_in = st_mode;
                  end
               end
               default: begin
                  b_v     = st_v;
                  b_tok   = st_tok;
                  b_line  = st_line;
                  b_col   = st_col;
                  mode_in = st_mode;
               end
            endcase
         end
      end
   end

   always_comb begin
      res_count = {1'b0, a_v} + {1'b0, b_v};
      res0_tok  = a_v ? a_tok : b_tok;
      res0_line = a_v ? a_line : b_line;
      res0_col  = a_v ? a_col : b_col;
      res1_tok  = b_tok;
      res1_line = b_line;
      res1_col  = b_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= POS_ONE;
         col_ff  <= POS_ZERO;
         nl_ff   <= 1'b0;
         done_ff <= 1'b0;
         skip_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         nl_ff   <= nl_in;
         done_ff <= done_in;
         skip_ff <= skip_in;
      end
   end

endmodule

[rtl/sct_result_fifo.sv]
// Four-entry result queue: takes up to two results, gives one per cycle on pop.
module sct_result_fifo import sct_pkg::*; #(
   parameter int POS_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  sct_tok_type          in0_tok,
   input  logic [POS_WIDTH-1:0] in0_line,
   input  logic [POS_WIDTH-1:0] in0_col,
   input  sct_tok_type          in1_tok,
   input  logic [POS_WIDTH-1:0] in1_line,
   input  logic [POS_WIDTH-1:0] in1_col,
   input  logic                 pop,
   output logic [FIFO_CW-1:0]   count,
   output sct_tok_type          out_tok,
   output logic [POS_WIDTH-1:0] out_line,
   output logic [POS_WIDTH-1:0] out_col
);

   sct_tok_type          tok_ff  [FIFO_DEPTH];
   logic [POS_WIDTH-1:0] line_ff [FIFO_DEPTH];
   logic [POS_WIDTH-1:0] col_ff  [FIFO_DEPTH];

   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic [FIFO_AW-1:0] wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + FIFO_AW'(1);
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push_count) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         tok_ff[wr_ptr_ff]  <= in0_tok;
         line_ff[wr_ptr_ff] <= in0_line;
         col_ff[wr_ptr_ff]  <= in0_col;
      end
      if (push_count == 2'd2) begin
         tok_ff[wr_next]  <= in1_tok;
         line_ff[wr_next] <= in1_line;
         col_ff[wr_next]  <= in1_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign count    = count_ff;
   assign out_tok  = tok_ff[rd_ptr_ff];
   assign out_line = line_ff[rd_ptr_ff];
   assign out_col  = col_ff[rd_ptr_ff];

endmodule

[rtl/shell_command_tokenizer.sv]
// Top level of the shell command tokenizer: input register, lexer and result queue.
// The req channel carries one byte or an end-of-input marker per transaction.
// The rsp channel carries one result per transaction: token kind, text byte,
// byte-valid, token-end and bad-character flags, and the line and column
// after a closed token or of a bad byte. A byte gives zero, one or two results.
// The csr channel writes the skip_whitespace register; it is always ready.
// A byte is held in the input register while it is classified, and its results
// are written to a four-entry queue, from which the first result is offered.
// One byte is taken per cycle while the queue has room for two results; the
// sustained rate is then set by the result port, which delivers one result per
// cycle while the receiver is ready.
// When the receiver stalls, the queue fills and req ready drops until space
// returns; nothing is lost or repeated.
// Reset clears the lexer to idle at line 1, column 0, empties the queue and
// clears skip_whitespace. After an end-of-input transaction every further
// byte is taken and gives no result until reset.
`include "shell_command_tokenizer_defines.svh"

module shell_command_tokenizer import sct_pkg::*; #(
   parameter int POS_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   sct_req_if.sink    req_bus,
   sct_rsp_if.source  rsp_bus,
   sct_csr_if.sink    csr_bus
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;

   logic       proc;
   logic       accept;
   logic       pop;

   logic [1:0]           push_count;
   sct_tok_type          res0_tok, res1_tok, out_tok;
   logic [POS_WIDTH-1:0] res0_line, res0_col, res1_line, res1_col;
   logic [POS_WIDTH-1:0] out_line, out_col;
   logic [FIFO_CW-1:0]   count;

   assign proc          = in_valid_ff && (count <= FIFO_CW'(FIFO_DEPTH - 2));
   assign req_bus.ready = !in_valid_ff || proc;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_bus.in_byte;
         in_eoi_ff  <= req_bus.end_of_input;
      end
   end

   sct_lexer #(
      .POS_WIDTH (POS_WIDTH)
   ) u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step         (proc),
      .in_byte      (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .cfg_we       (csr_bus.valid),
      .cfg_skip     (csr_bus.skip_whitespace),
      .res_count    (push_count),
      .res0_tok     (res0_tok),
      .res0_line    (res0_line),
      .res0_col     (res0_col),
      .res1_tok     (res1_tok),
      .res1_line    (res1_line),
      .res1_col     (res1_col)
   );

   sct_result_fifo #(
      .POS_WIDTH (POS_WIDTH)
   ) u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .in0_tok    (res0_tok),
      .in0_line   (res0_line),
      .in0_col    (res0_col),
      .in1_tok    (res1_tok),
      .in1_line   (res1_line),
      .in1_col    (res1_col),
      .pop        (pop),
      .count      (count),
      .out_tok    (out_tok),
      .out_line   (out_line),
      .out_col    (out_col)
   );

   assign rsp_bus.valid      = (count != '0);
   assign rsp_bus.token_kind = out_tok.token_kind;
   assign rsp_bus.text_byte  = out_tok.text_byte;
   assign rsp_bus.byte_valid = out_tok.byte_valid;
   assign rsp_bus.token_end  = out_tok.token_end;
   assign rsp_bus.bad_char   = out_tok.bad_char;
   assign rsp_bus.pos_line   = out_line;
   assign rsp_bus.pos_column = out_col;

   `SCT_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count <= FIFO_CW'(FIFO_DEPTH),
                    "result queue over capacity")
   `SCT_ASSERT_NEXT(a_held_byte, clock, reset, in_valid_ff && !proc,
                    in_valid_ff && $stable(in_byte_ff), "held byte lost")
   `SCT_ASSERT_NEXT(a_silent_after_end, clock, reset, proc && in_eoi_ff, push_count == 2'd0,
                    "result after end of input")

endmodule

[test/shell_command_tokenizer_test.sv]
// Self-checking testbench for the shell command tokenizer: directed table, random token streams.
module shell_command_tokenizer_test;
   import sct_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 250;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  text;
      logic        has_byte;
      logic        last;
      logic        bad;
      logic [15:0] line;
      logic [15:0] column;
   } tok_rec_t;

   typedef struct {
      logic [7:0] data;
      int         typed;
      tok_rec_t   first;
      tok_rec_t   second;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset;

   sct_req_if                     req_bus ();
   sct_rsp_if #(.POS_WIDTH(16))   rsp_bus ();
   sct_csr_if                     csr_bus ();

   shell_command_tokenizer #(.POS_WIDTH(16)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Tokenizer state as the testbench tracks it.
   logic [2:0]  lex_state;
   logic [15:0] line_no;
   logic [15:0] col_no;
   logic        after_newline;
   logic        stream_done;
   logic        skip_ws;

   tok_rec_t    step_tokens[$];
   tok_rec_t    pending_tokens[$];
   stim_row_t   rows[$];

   int          typed_n = -1;
   tok_rec_t    typed_first;
   tok_rec_t    typed_second;

   int          mismatch_count;
   int          results_seen;
   int          items_sent;
   int          quiet_cycles;
   bit          steady;
   bit          stall_rsp_now;

   function automatic tok_rec_t make_tok(logic [2:0] kind, logic [7:0] text, logic has_byte,
                                         logic last, logic bad, logic [15:0] line,
                                         logic [15:0] column);
      tok_rec_t t;
      t.kind     = kind;
      t.text     = has_byte ? text : 8'h00;
      t.has_byte = has_byte;
      t.last     = last;
      t.bad      = bad;
      t.line     = line;
      t.column   = column;
      return t;
   endfunction

   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic word_byte(logic [7:0] b);
      return (b inside {["0":"9"], ["A":"Z"], ["a":"z"], "?", "#", "/", "-", ".", "*", "@",
                        ":", "%", "!", "^", ",", "+", "(", ")", "'", "[", "]", "{", "}",
                        "=", "$", "_", "~", 8'h60});
   endfunction

   function automatic logic blank(logic [7:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
   endfunction

   function automatic void put_text(logic [2:0] kind, logic [7:0] b);
      step_tokens.push_back(make_tok(kind, b, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0));
   endfunction

   function automatic void put_close(logic [2:0] kind);
      step_tokens.push_back(make_tok(kind, 8'h00, 1'b0, 1'b1, 1'b0, line_no, col_no));
   endfunction

   function automatic void put_op(logic [2:0] kind, logic [7:0] b);
      step_tokens.push_back(make_tok(kind, b, 1'b1, 1'b1, 1'b0, line_no, bump(col_no)));
   endfunction

   function automatic void advance_pos(logic newline);
      if (after_newline) begin
         line_no = bump(line_no);
         col_no  = 16'd0;
      end
      col_no        = bump(col_no);
      after_newline = newline;
   endfunction

   function automatic void open_token(logic [7:0] b);
      lex_state = MODE_IDLE;
      if (word_byte(b)) begin
         lex_state = MODE_WORD;
         put_text(KIND_LIT, b);
      end else if (blank(b)) begin
         lex_state = MODE_SPACE;
         if (!skip_ws) put_text(KIND_SPACE, b);
      end else if (b == CH_BSLASH) begin
         lex_state = MODE_LEAD_ESC;
      end else if (b == CH_QUOTE) begin
         lex_state = MODE_QUOTE;
      end else if (b == CH_GT) begin
         lex_state = MODE_GREATER;
      end else if (b == CH_LT) begin
         put_op(KIND_IN, b);
      end else if (b == CH_PIPE) begin
         put_op(KIND_PIPE, b);
      end else if (b == CH_SEMI) begin
         put_op(KIND_SEMI, b);
      end else if (b == CH_AMP) begin
         put_op(KIND_AND, b);
      end else begin
         step_tokens.push_back(make_tok(KIND_LIT, b, 1'b1, 1'b0, 1'b1, line_no, col_no));
      end
   endfunction

   function automatic void tokenize_byte(logic [7:0] b, logic eoi);
      if (stream_done) return;
      if (eoi) begin
         advance_pos(1'b0);
         case (lex_state)
            MODE_WORD, MODE_WORD_ESC, MODE_QUOTE: put_close(KIND_LIT);
            MODE_QUOTE_ESC: begin
               put_text(KIND_LIT, CH_BSLASH);
               put_close(KIND_LIT);
            end
            MODE_SPACE: if (!skip_ws) put_close(KIND_SPACE);
            MODE_GREATER: step_tokens.push_back(make_tok(KIND_OUT, CH_GT, 1'b1, 1'b1, 1'b0,
                                                         line_no, col_no));
            default: ;
         endcase
         lex_state   = MODE_IDLE;
         stream_done = 1'b1;
         return;
      end
      advance_pos(b == CH_LF);
      case (lex_state)
         MODE_WORD: begin
            if (word_byte(b)) begin
               put_text(KIND_LIT, b);
            end else if (b == CH_BSLASH) begin
               lex_state = MODE_WORD_ESC;
            end else begin
               put_close(KIND_LIT);
               open_token(b);
            end
         end
         MODE_WORD_ESC, MODE_LEAD_ESC: begin
            put_text(KIND_LIT, b);
            lex_state = MODE_WORD;
         end
         MODE_QUOTE: begin
            if (b == CH_QUOTE) begin
               put_op(KIND_LIT, 8'h00);
               step_tokens[step_tokens.size() - 1] = make_tok(KIND_LIT, 8'h00, 1'b0, 1'b1, 1'b0,
                                                              line_no, bump(col_no));
               lex_state = MODE_IDLE;
            end else if (b == CH_BSLASH) begin
               lex_state = MODE_QUOTE_ESC;
            end else begin
               put_text(KIND_LIT, b);
            end
         end
         MODE_QUOTE_ESC: begin
            if (b != CH_QUOTE) put_text(KIND_LIT, CH_BSLASH);
            put_text(KIND_LIT, b);
            lex_state = MODE_QUOTE;
         end
         MODE_SPACE: begin
            if (blank(b)) begin
               if (!skip_ws) put_text(KIND_SPACE, b);
            end else begin
               if (!skip_ws) put_close(KIND_SPACE);
               open_token(b);
            end
         end
         MODE_GREATER: begin
            if (b == CH_GT) begin
               put_text(KIND_APPEND, CH_GT);
               put_op(KIND_APPEND, CH_GT);
               lex_state = MODE_IDLE;
            end else begin
               step_tokens.push_back(make_tok(KIND_OUT, CH_GT, 1'b1, 1'b1, 1'b0, line_no, col_no));
               open_token(b);
            end
         end
         default: open_token(b);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t result %0d: %s is %0h, %0h expected", $realtime, results_seen, what, got,
                  want);
   endtask

   always @(posedge clock) begin : monitor
      tok_rec_t want;
      if (reset) begin
         lex_state     = MODE_IDLE;
         line_no       = 16'd1;
         col_no        = 16'd0;
         after_newline = 1'b0;
         stream_done   = 1'b0;
         skip_ws       = 1'b0;
         pending_tokens.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            step_tokens.delete();
            tokenize_byte(req_bus.in_byte, req_bus.end_of_input);
            if (typed_n >= 0) begin
               if (typed_n > 0) pending_tokens.push_back(typed_first);
               if (typed_n > 1) pending_tokens.push_back(typed_second);
            end else begin
               foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
            end
         end
         if (csr_bus.valid && csr_bus.ready) skip_ws = csr_bus.skip_whitespace;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_tokens.size() == 0) begin
               report_mismatch("unrequested result, text_byte", 16'(rsp_bus.text_byte), 16'h0);
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_bus.token_kind !== want.kind)
                  report_mismatch("token_kind", 16'(rsp_bus.token_kind), 16'(want.kind));
               if (rsp_bus.text_byte !== want.text)
                  report_mismatch("text_byte", 16'(rsp_bus.text_byte), 16'(want.text));
               if (rsp_bus.byte_valid !== want.has_byte)
                  report_mismatch("byte_valid", 16'(rsp_bus.byte_valid), 16'(want.has_byte));
               if (rsp_bus.token_end !== want.last)
                  report_mismatch("token_end", 16'(rsp_bus.token_end), 16'(want.last));
               if (rsp_bus.bad_char !== want.bad)
                  report_mismatch("bad_char", 16'(rsp_bus.bad_char), 16'(want.bad));
               if (rsp_bus.pos_line !== want.line)
                  report_mismatch("pos_line", rsp_bus.pos_line, want.line);
               if (rsp_bus.pos_column !== want.column)
                  report_mismatch("pos_column", rsp_bus.pos_column, want.column);
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("shell_command_tokenizer: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_pacing
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_rsp_now) begin
            stall_rsp_now = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 18);
      end
   end

   task automatic offer(logic [7:0] b, logic eoi, int typed, tok_rec_t first, tok_rec_t second);
      while (!steady && $urandom_range(99) < 18) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.in_byte      <= b;
      req_bus.end_of_input <= eoi;
      typed_n              <= typed;
      typed_first          <= first;
      typed_second         <= second;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      offer(b, 1'b0, -1, '0, '0);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_skip(logic value);
      wait_drained();
      csr_bus.valid           <= 1'b1;
      csr_bus.skip_whitespace <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic add_row(logic [7:0] b, int typed, tok_rec_t first, tok_rec_t second);
      rows.push_back('{b, typed, first, second});
   endtask

   function automatic logic [7:0] any_word_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (!word_byte(b));
      return b;
   endfunction

   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (word_byte(b) || blank(b) ||
             (b inside {CH_BSLASH, CH_QUOTE, CH_GT, CH_LT, CH_PIPE, CH_SEMI, CH_AMP}));
      return b;
   endfunction

   task automatic send_fragment();
      int         pick;
      int         len;
      logic [7:0] b;
      pick = $urandom_range(99);
      len  = $urandom_range(6, 1);
      if (pick < 30) begin
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 15) begin
               send_byte(CH_BSLASH);
               send_byte(8'($urandom_range(255)));
            end else begin
               send_byte(any_word_byte());
            end
         end
      end else if (pick < 45) begin
         send_byte(CH_QUOTE);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
               0: begin
                  send_byte(CH_BSLASH);
                  send_byte(CH_QUOTE);
               end
               1: begin
                  send_byte(CH_BSLASH);
                  send_byte(8'($urandom_range(255)));
               end
               2: begin
                  b = 8'($urandom_range(255));
                  send_byte((b == CH_QUOTE) ? 8'hA2 : b);
               end
               default: begin
                  b = 8'($urandom_range(8'h7E, 8'h20));
                  send_byte((b == CH_QUOTE || b == CH_BSLASH) ? "q" : b);
               end
            endcase
         end
         if ($urandom_range(9) != 0) send_byte(CH_QUOTE);
      end else if (pick < 60) begin
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(3))
               0: send_byte(CH_SPACE);
               1: send_byte(CH_TAB);
               2: send_byte(CH_CR);
               default: send_byte(CH_LF);
            endcase
         end
      end else if (pick < 75) begin
         case ($urandom_range(5))
            0: send_byte(CH_LT);
            1: send_byte(CH_GT);
            2: begin
               send_byte(CH_GT);
               send_byte(CH_GT);
            end
            3: send_byte(CH_PIPE);
            4: send_byte(CH_SEMI);
            default: send_byte(CH_AMP);
         endcase
      end else if (pick < 85) begin
         send_byte(stray_byte());
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic return_to_idle();
      forever begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         if (lex_state == MODE_IDLE) return;
         case (lex_state)
            MODE_QUOTE: send_byte(CH_QUOTE);
            MODE_WORD, MODE_SPACE: send_byte(CH_SEMI);
            MODE_GREATER: send_byte(CH_GT);
            default: send_byte("x");
         endcase
      end
   endtask

   initial begin : stimulus
      tok_rec_t none;
      none = '0;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.in_byte         <= 8'h00;
      req_bus.end_of_input    <= 1'b0;
      csr_bus.valid           <= 1'b0;
      csr_bus.skip_whitespace <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(8'h00, 1, make_tok(KIND_LIT, 8'h00, 1'b1, 1'b0, 1'b1, 16'd1, 16'd1), none);
      add_row(8'hFF, 1, make_tok(KIND_LIT, 8'hFF, 1'b1, 1'b0, 1'b1, 16'd1, 16'd2), none);
      add_row(CH_LT, 1, make_tok(KIND_IN, CH_LT, 1'b1, 1'b1, 1'b0, 16'd1, 16'd4), none);
      add_row(CH_PIPE, 1, make_tok(KIND_PIPE, CH_PIPE, 1'b1, 1'b1, 1'b0, 16'd1, 16'd5), none);
      add_row(CH_SEMI, 1, make_tok(KIND_SEMI, CH_SEMI, 1'b1, 1'b1, 1'b0, 16'd1, 16'd6), none);
      add_row(CH_AMP, 1, make_tok(KIND_AND, CH_AMP, 1'b1, 1'b1, 1'b0, 16'd1, 16'd7), none);
      add_row(CH_GT, 0, none, none);
      add_row(CH_GT, 2, make_tok(KIND_APPEND, CH_GT, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0),
              make_tok(KIND_APPEND, CH_GT, 1'b1, 1'b1, 1'b0, 16'd1, 16'd9));
      add_row(CH_GT, -1, none, none);
      add_row("a", -1, none, none);
      add_row(CH_BSLASH, -1, none, none);
      add_row(8'h80, -1, none, none);
      add_row(CH_SPACE, -1, none, none);
      add_row(CH_LF, -1, none, none);
      add_row(CH_QUOTE, -1, none, none);
      add_row(CH_BSLASH, -1, none, none);
      add_row(CH_QUOTE, -1, none, none);
      add_row(CH_BSLASH, -1, none, none);
      add_row("n", -1, none, none);
      add_row(8'h00, -1, none, none);
      add_row(CH_QUOTE, -1, none, none);
      add_row(CH_BSLASH, -1, none, none);
      add_row(CH_BSLASH, -1, none, none);
      add_row(CH_GT, -1, none, none);
      add_row(CH_TAB, -1, none, none);
      add_row(CH_CR, -1, none, none);
      add_row("9", -1, none, none);
      add_row(8'h7F, -1, none, none);

      write_skip(1'b0);
      foreach (rows[i]) offer(rows[i].data, 1'b0, rows[i].typed, rows[i].first, rows[i].second);

      for (int phase = 0; phase < 4; phase++) begin
         write_skip(phase % 2 == 0);
         steady = (phase == 1);
         if (phase == 0) stall_rsp_now = 1'b1;
         while (items_sent < 28 + (phase + 1) * PHASE_ITEMS) send_fragment();
      end

      // Leave one kind of token open, or none, when the end of input arrives.
      return_to_idle();
      write_skip(1'($urandom_range(1)));
      case ($urandom_range(7))
         1: begin
            send_byte("a");
            send_byte("b");
         end
         2: begin
            send_byte("a");
            send_byte(CH_BSLASH);
         end
         3: send_byte(CH_BSLASH);
         4: begin
            send_byte(CH_QUOTE);
            send_byte("a");
         end
         5: begin
            send_byte(CH_QUOTE);
            send_byte(CH_BSLASH);
         end
         6: send_byte(CH_SPACE);
         7: send_byte(CH_GT);
         default: ;
      endcase
      offer(8'($urandom_range(255)), 1'b1, -1, none, none);
      repeat (4) send_byte(8'($urandom_range(255)));
      wait_drained();

      if (mismatch_count == 0 && pending_tokens.size() == 0) begin
         $display("shell_command_tokenizer: match");
      end else begin
         $display("shell_command_tokenizer: mismatch");
      end
      $finish;
   end

endmodule
